[rtl/rgba_mip_chain_box_downsample_core_macros.svh]
// Assertion macros for the mip chain downsampler checker.
// Uses clk_i and rst_ni of the scope that expands them.
`ifndef RGBA_MIP_CHAIN_BOX_DOWNSAMPLE_CORE_MACROS_SVH
`define RGBA_MIP_CHAIN_BOX_DOWNSAMPLE_CORE_MACROS_SVH

// Checked on every rising edge outside of reset.
`define RMCB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define RMCB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/rmcb_pkg.sv]
// Shared types and constants of the mip chain box downsampler.
// No dependencies; used by the level cells, the top level and the checker.
package rmcb_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned NUM_CH    = 4;
  localparam int unsigned SUM_W     = 10;
  localparam int unsigned LEVEL_W   = 4;
  localparam int unsigned COORD_W   = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 2'd0,
    CFG_SOURCE_HEIGHT = 2'd1,
    CFG_SINGLE_LEVEL  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } in_pix_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] mip_level;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [CH_W-1:0]    out_red;
    logic [CH_W-1:0]    out_green;
    logic [CH_W-1:0]    out_blue;
    logic [CH_W-1:0]    out_alpha;
    logic               last_of_run;
  } out_res_t;

  // Status a cell shows to the cell above it.
  typedef struct packed {
    logic en;
    logic would_emit;
  } nbr_t;

  // Per-cell control seen by the top level.
  typedef struct packed {
    logic emit;
    logic pass;
    logic busy;
  } cell_ctl_t;

endpackage

[rtl/rmcb_level_cell.sv]
// One mip level of the downsampling chain: counters, held left pixel and
// the even-row pair sum memory. Depends on rmcb_pkg.
module rmcb_level_cell #(
  parameter int unsigned LEVEL      = 0,
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    src_width_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   src_height_i,
  input  logic                              single_i,
  input  logic                              restart_i,
  input  logic                              load_i,
  input  rmcb_pkg::in_pix_t                 load_pix_i,
  input  logic                              out_free_i,
  input  rmcb_pkg::nbr_t                    nbr_i,
  output rmcb_pkg::nbr_t                    nbr_o,
  output rmcb_pkg::cell_ctl_t               ctl_o,
  output rmcb_pkg::out_res_t                res_o,
  output rmcb_pkg::in_pix_t                 pix_o
);

  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned SLOTS = ((MAX_WIDTH >> (LEVEL + 1)) > 1) ?
                                  (MAX_WIDTH >> (LEVEL + 1)) : 1;
  localparam int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned CH_W  = rmcb_pkg::CH_W;
  localparam int unsigned SUM_W = rmcb_pkg::SUM_W;
  localparam int unsigned NCH   = rmcb_pkg::NUM_CH;

  logic                      tok_v_q, tok_v_d;
  rmcb_pkg::in_pix_t         tok_pix_q;
  logic [WW-1:0]             c_q, c_d;
  logic [HW-1:0]             r_q, r_d;
  logic [NCH-1:0][CH_W-1:0]  held_q;
  logic [NCH-1:0][SUM_W-1:0] mem_q [DEPTH];
  logic [NCH-1:0][SUM_W-1:0] rd_q;

  logic [WW-1:0]             w_shift, pw;
  logic [HW-1:0]             h_shift, ph;
  logic                      pw1, ph1, en, pair_ok, row_ok, emit_ok;
  logic                      fire, emit, pass, upd, held_we, mem_we;
  logic [AW-1:0]             waddr, raddr;
  logic [NCH-1:0][CH_W-1:0]  p_w, avg;
  logic [NCH-1:0][CH_W:0]    pair;
  logic [NCH-1:0][SUM_W-1:0] wdata;
  logic [WW:0]               c_inc;
  logic [HW:0]               r_inc;
  logic [WW-1:0]             x_pos;
  logic [HW-1:0]             y_pos;

  // Level size is the level-0 size halved LEVEL times, never below one.
  assign w_shift = src_width_i >> LEVEL;
  assign h_shift = src_height_i >> LEVEL;
  assign pw      = (w_shift == '0) ? WW'(1) : w_shift;
  assign ph      = (h_shift == '0) ? HW'(1) : h_shift;
  assign pw1     = (pw == WW'(1));
  assign ph1     = (ph == HW'(1));
  assign en      = !single_i && (!pw1 || !ph1);

  assign pair_ok = pw1 || c_q[0];
  assign row_ok  = ph1 || r_q[0];
  assign emit_ok = pair_ok && row_ok;

  assign fire    = tok_v_q && (out_free_i || !(en && emit_ok));
  assign upd     = fire && en;
  assign emit    = upd && emit_ok;
  assign pass    = emit && nbr_i.en;
  assign held_we = upd && !pw1 && !c_q[0];
  assign mem_we  = upd && pair_ok && !ph1 && !r_q[0];

  assign nbr_o.en         = en;
  assign nbr_o.would_emit = emit_ok;

  assign ctl_o.emit = emit;
  assign ctl_o.pass = pass;
  assign ctl_o.busy = tok_v_q && !(fire && !pass);

  assign p_w   = tok_pix_q;
  assign waddr = c_q[AW:1];
  assign raddr = c_d[AW:1];

  always_comb begin
    logic [SUM_W:0] s;
    s = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      if (pw1) begin
        pair[ch] = {p_w[ch], 1'b0};
      end else begin
        pair[ch] = {1'b0, held_q[ch]} + {1'b0, p_w[ch]};
      end
      wdata[ch] = SUM_W'(pair[ch]);
      s = (SUM_W + 1)'(rd_q[ch]) + (SUM_W + 1)'(pair[ch]);
      if (ph1) begin
        avg[ch] = pair[ch][CH_W:1];
      end else begin
        avg[ch] = s[CH_W+1:2];
      end
    end
  end

  // Advance column and row; wrap both at the end of the level's source.
  always_comb begin
    c_inc = {1'b0, c_q} + (WW + 1)'(1);
    r_inc = {1'b0, r_q} + (HW + 1)'(1);
    c_d   = c_q;
    r_d   = r_q;
    if (restart_i) begin
      c_d = '0;
      r_d = '0;
    end else if (upd) begin
      if (c_inc >= {1'b0, pw}) begin
        c_d = '0;
        r_d = (r_inc >= {1'b0, ph}) ? '0 : r_inc[HW-1:0];
      end else begin
        c_d = c_inc[WW-1:0];
      end
    end
  end

  always_comb begin
    tok_v_d = tok_v_q;
    if (load_i) begin
      tok_v_d = 1'b1;
    end else if (fire) begin
      tok_v_d = 1'b0;
    end
  end

  assign x_pos = c_q >> 1;
  assign y_pos = r_q >> 1;

  always_comb begin
    res_o.mip_level   = rmcb_pkg::LEVEL_W'(LEVEL + 1);
    res_o.out_col     = rmcb_pkg::COORD_W'(x_pos);
    res_o.out_row     = rmcb_pkg::COORD_W'(y_pos);
    res_o.out_red     = avg[3];
    res_o.out_green   = avg[2];
    res_o.out_blue    = avg[1];
    res_o.out_alpha   = avg[0];
    res_o.last_of_run = !(nbr_i.en && nbr_i.would_emit);
  end

  assign pix_o = rmcb_pkg::in_pix_t'(avg);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_v_q <= 1'b0;
      c_q     <= '0;
      r_q     <= '0;
    end else begin
      tok_v_q <= tok_v_d;
      c_q     <= c_d;
      r_q     <= r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tok_pix_q <= load_pix_i;
    end
    if (held_we) begin
      held_q <= p_w;
    end
  end

  // Pair sum store; read follows the next column so data is ready on arrival.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_we && (waddr == raddr)) begin
      rd_q <= wdata;
    end else begin
      rd_q <= mem_q[raddr];
    end
  end

endmodule

[rtl/rgba_mip_chain_box_downsample_core.sv]
// Mip chain generator, 2x2 box filter on RGBA8, one level cell per mip level.
// Path: a level-L result passes the token register of each cell up to the emitting one, then the output register.
// Throughput: one pixel per cycle while it causes no result; each result also hands the
// request on to the next active level cell, one level a cycle while the output is free,
// and the input waits until the chain of results stops.
// Reset: counters cleared, width and height 1, single level off; stores unset.
module rgba_mip_chain_box_downsample_core #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned MAX_LEVELS = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  rmcb_pkg::in_pix_t                      in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output rmcb_pkg::out_res_t                     out_data_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [rmcb_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [rmcb_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  logic [WW-1:0]          w0_q;
  logic [HW-1:0]          h0_q;
  logic                   single_q;
  logic                   restart;
  logic                   in_acc;
  logic                   out_free;
  logic                   out_v_q, out_v_d;
  logic                   emit_any;
  rmcb_pkg::out_res_t     out_q, out_d;

  rmcb_pkg::nbr_t         nbr [MAX_LEVELS+1];
  rmcb_pkg::cell_ctl_t    ctl [MAX_LEVELS];
  rmcb_pkg::out_res_t     res [MAX_LEVELS];
  rmcb_pkg::in_pix_t      pix [MAX_LEVELS];
  logic [MAX_LEVELS-1:0]  busy;

  function automatic logic [31:0] clamp_size(input logic [rmcb_pkg::CFG_DATA_W-1:0] v,
                                             input int unsigned hi);
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 == 32'd0) begin
      return 32'd1;
    end
    if (v32 > hi) begin
      return 32'(hi);
    end
    return v32;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign restart     = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w0_q     <= WW'(1);
      h0_q     <= HW'(1);
      single_q <= 1'b0;
    end else if (restart) begin
      case (cfg_index_i)
        rmcb_pkg::CFG_SOURCE_WIDTH: begin
          w0_q <= WW'(clamp_size(cfg_data_i, MAX_WIDTH));
        end
        rmcb_pkg::CFG_SOURCE_HEIGHT: begin
          h0_q <= HW'(clamp_size(cfg_data_i, MAX_HEIGHT));
        end
        rmcb_pkg::CFG_SINGLE_LEVEL: begin
          single_q <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign out_free = !out_v_q || out_ready_i;

  // Take a new pixel only when no earlier request will still emit.
  assign in_ready_o = ~|busy;
  assign in_acc     = in_valid_i && in_ready_o;

  assign nbr[MAX_LEVELS] = '0;

  for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
    logic              load;
    rmcb_pkg::in_pix_t load_pix;

    if (k == 0) begin : g_head
      assign load     = in_acc;
      assign load_pix = in_data_i;
    end else begin : g_link
      assign load     = ctl[k-1].pass;
      assign load_pix = pix[k-1];
    end

    rmcb_level_cell #(
      .LEVEL      (k),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .src_width_i  (w0_q),
      .src_height_i (h0_q),
      .single_i     (single_q),
      .restart_i    (restart),
      .load_i       (load),
      .load_pix_i   (load_pix),
      .out_free_i   (out_free),
      .nbr_i        (nbr[k+1]),
      .nbr_o        (nbr[k]),
      .ctl_o        (ctl[k]),
      .res_o        (res[k]),
      .pix_o        (pix[k])
    );

    assign busy[k] = ctl[k].busy;
  end

  // At most one cell emits in a cycle.
  always_comb begin
    out_d    = out_q;
    emit_any = 1'b0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      if (ctl[k].emit) begin
        out_d    = res[k];
        emit_any = 1'b1;
      end
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (emit_any) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_any) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

[rtl/rmcb_checker.sv]
// Port-level checks of the mip chain downsampler and their bind.
// Depends on rmcb_pkg and the assertion macro header.
`include "rgba_mip_chain_box_downsample_core_macros.svh"

module rmcb_checker #(
  parameter int unsigned MAX_LEVELS = 12
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input rmcb_pkg::out_res_t out_data_o
);

  localparam logic [rmcb_pkg::LEVEL_W-1:0] LVL_MAX = rmcb_pkg::LEVEL_W'(MAX_LEVELS);

  logic                         expect_q;
  logic [rmcb_pkg::LEVEL_W-1:0] exp_lvl_q;

  // Track the level the next result of a run must carry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q  <= 1'b0;
      exp_lvl_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      expect_q  <= !out_data_o.last_of_run;
      exp_lvl_q <= out_data_o.mip_level + rmcb_pkg::LEVEL_W'(1);
    end
  end

  `RMCB_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result dropped or changed while stalled")
  `RMCB_ASSERT(a_run_start, out_valid_o && !expect_q |-> out_data_o.mip_level == rmcb_pkg::LEVEL_W'(1), "run does not start at level one")
  `RMCB_ASSERT(a_run_next, out_valid_o && expect_q |-> out_data_o.mip_level == exp_lvl_q, "run skips or repeats a level")
  `RMCB_ASSERT(a_level_cap, out_valid_o && !out_data_o.last_of_run |-> out_data_o.mip_level < LVL_MAX, "run continues past deepest level")
  `RMCB_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "result shown during reset")

endmodule

bind rgba_mip_chain_box_downsample_core rmcb_checker #(
  .MAX_LEVELS (MAX_LEVELS)
) u_rmcb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
